// ===== rtl/psc_pkg.sv =====
// Shared constants, types and the arctangent table of the polar sector classifier.
package psc_pkg;

  // Angle resolution in bits of a turn and the number of CORDIC micro-rotations.
  localparam int ANGLE_BITS    = 16;
  localparam int CORDIC_STAGES = 16;
  localparam int MAX_SECTORS   = 64;

  // Fixed field widths.
  localparam int COORD_W  = 16;
  localparam int RADIUS_W = 16;
  localparam int COUNT_W  = 7;
  localparam int SECTOR_W = 6;
  localparam int REGION_W = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Squares of coordinates and radii, and their sum, fit in 32 bits.
  localparam int SQ_W = 2 * COORD_W;

  // Extra fractional bits in the CORDIC datapath.
  localparam int GUARD_BITS = 8;
  // Guarded coordinate plus headroom for the CORDIC gain and the sqrt(2) of the diagonal.
  localparam int CORDIC_W   = COORD_W + GUARD_BITS + 3;

  localparam int TABLE_LEN = 24;

  // atan(2^-i) as a fraction of a turn, scaled by 2^32.
  localparam logic [31:0] ATAN_TURN32 [TABLE_LEN] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C,
    32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
    32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
  };

  typedef enum logic [REGION_W-1:0] {
    REGION_RING  = 2'd0,
    REGION_INNER = 2'd1,
    REGION_OUTER = 2'd2
  } psc_region_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SEGMENT_COUNT = 2'd0,
    REG_INNER_RADIUS  = 2'd1,
    REG_OUTER_RADIUS  = 2'd2
  } psc_reg_e;

  // Vector and angle accumulator carried through the CORDIC stages.
  typedef struct packed {
    logic signed [CORDIC_W-1:0] x;
    logic signed [CORDIC_W-1:0] y;
    logic [ANGLE_BITS-1:0]      z;
  } psc_vec_t;

  // Classification that travels beside the vector.
  typedef struct packed {
    logic        origin;
    psc_region_e region;
  } psc_side_t;

  // Table entry rounded to ANGLE_BITS bits: add half an LSB, then shift.
  function automatic logic [ANGLE_BITS-1:0] atan_entry(logic [4:0] idx);
    logic [32:0] sum;
    sum = {1'b0, ATAN_TURN32[idx]};
    if (ANGLE_BITS < 32) begin
      sum = sum + (33'd1 << (32 - ANGLE_BITS - 1));
    end
    return ANGLE_BITS'(sum >> (32 - ANGLE_BITS));
  endfunction

endpackage

// ===== rtl/psc_point_if.sv =====
// Stream interface that carries one point per beat.
interface psc_point_if;
  logic                                valid;
  logic                                ready;
  logic signed [psc_pkg::COORD_W-1:0]  x_pos;
  logic signed [psc_pkg::COORD_W-1:0]  y_pos;

  modport source (output valid, output x_pos, output y_pos, input ready);
  modport sink (input valid, input x_pos, input y_pos, output ready);
endinterface

// ===== rtl/psc_result_if.sv =====
// Stream interface that carries one classification result per beat.
interface psc_result_if;
  logic                            valid;
  logic                            ready;
  logic [psc_pkg::SECTOR_W-1:0]    sector;
  logic [psc_pkg::REGION_W-1:0]    region;

  modport source (output valid, output sector, output region, input ready);
  modport sink (input valid, input sector, input region, output ready);
endinterface

// ===== rtl/psc_cfg_if.sv =====
// Register write interface: one register index and its data per beat.
interface psc_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [psc_pkg::CFG_IDX_W-1:0]     index;
  logic [psc_pkg::CFG_DATA_W-1:0]    wdata;

  modport source (output valid, output index, output wdata, input ready);
  modport sink (input valid, input index, input wdata, output ready);
endinterface

// ===== rtl/polar_sector_classifier_unit.sv =====
// Top level of the polar sector classifier: ring region test and CORDIC sector index.
//
// Each beat on point_i carries a centred point (x_pos, y_pos) in signed Q15 and yields
// exactly one beat on result_o. The squared radius is compared exactly with the squared
// inner and outer radii to give the region (0 on the ring, 1 inside the inner radius,
// 2 beyond the outer radius, which wins when both hold). For points on the ring the angle
// counter-clockwise from +x is found as a 16-bit fraction of a turn by a vectoring CORDIC,
// and the sector is floor(angle * count / 65536), with a count of 0 taken as 1 and one
// above 64 taken as 64; the origin has angle 0. The block accepts one point per clock
// unless the output stalls, and a result passes through one input register, one
// register for the squares and the half-plane fold, one register for each of the 16
// CORDIC micro-rotations, and the output register after the sector multiply. The whole
// pipeline holds while a result waits at the output, so point_i.ready is high whenever
// the output register is empty or its beat is taken in the same cycle. Registers are
// written through cfg_i, which is always ready; they are expected to change only while
// no point is in flight.
module polar_sector_classifier_unit (
  input  logic          clk_i,
  input  logic          rst_ni,
  psc_point_if.sink     point_i,
  psc_result_if.source  result_o,
  psc_cfg_if.sink       cfg_i
);

  localparam int A  = psc_pkg::ANGLE_BITS;
  localparam int CW = psc_pkg::CORDIC_W;

  // Configuration registers and values derived from them.
  logic [psc_pkg::COUNT_W-1:0]  seg_count_q;
  logic [psc_pkg::RADIUS_W-1:0] inner_q, outer_q;
  logic [psc_pkg::SQ_W-1:0]     in2_q, out2_q;
  logic [psc_pkg::COUNT_W-1:0]  count_q, count_d;

  // Stage 1: input register.
  logic                               s1_vld_q;
  logic signed [psc_pkg::COORD_W-1:0] s1_x_q, s1_y_q;

  // Stage 2: squares and folded vector.
  logic                     s2_vld_q;
  logic [psc_pkg::SQ_W-1:0] s2_xx_q, s2_yy_q;
  logic                     s2_origin_q;
  psc_pkg::psc_vec_t        s2_vec_q, s2_vec_d;
  logic signed [psc_pkg::SQ_W-1:0] xx_s, yy_s;
  logic signed [CW-1:0]     xg, yg;

  // Region decision feeding the CORDIC side band.
  logic [psc_pkg::SQ_W-1:0] r2;
  psc_pkg::psc_side_t       side_d;

  // CORDIC output.
  logic                     c_vld;
  logic [A-1:0]             c_angle;
  psc_pkg::psc_side_t       c_side;

  // Output register.
  logic                          out_vld_q;
  logic [psc_pkg::SECTOR_W-1:0]  sector_q, sector_d;
  psc_pkg::psc_region_e          region_q;
  logic [A-1:0]                  angle_eff;
  logic [A+psc_pkg::COUNT_W-1:0] prod;

  logic en;

  // The pipeline advances whenever the output register can take a new beat.
  assign en            = !out_vld_q || result_o.ready;
  assign point_i.ready = en;
  assign cfg_i.ready   = 1'b1;

  // Register writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_count_q <= psc_pkg::COUNT_W'(10);
      inner_q     <= psc_pkg::RADIUS_W'(3277);
      outer_q     <= psc_pkg::RADIUS_W'(13107);
    end else if (cfg_i.valid) begin
      unique case (psc_pkg::psc_reg_e'(cfg_i.index))
        psc_pkg::REG_SEGMENT_COUNT: seg_count_q <= cfg_i.wdata[psc_pkg::COUNT_W-1:0];
        psc_pkg::REG_INNER_RADIUS:  inner_q     <= cfg_i.wdata[psc_pkg::RADIUS_W-1:0];
        psc_pkg::REG_OUTER_RADIUS:  outer_q     <= cfg_i.wdata[psc_pkg::RADIUS_W-1:0];
        default: ;
      endcase
    end
  end

  // A count of zero behaves as one sector; counts above the maximum saturate.
  always_comb begin
    count_d = seg_count_q;
    if (seg_count_q == '0) begin
      count_d = psc_pkg::COUNT_W'(1);
    end else if (int'(seg_count_q) > psc_pkg::MAX_SECTORS) begin
      count_d = psc_pkg::COUNT_W'(psc_pkg::MAX_SECTORS);
    end
  end

  // Derived values are registered from the configuration registers.
  always_ff @(posedge clk_i) begin
    in2_q   <= psc_pkg::SQ_W'(inner_q) * psc_pkg::SQ_W'(inner_q);
    out2_q  <= psc_pkg::SQ_W'(outer_q) * psc_pkg::SQ_W'(outer_q);
    count_q <= count_d;
  end

  // Stage 1.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (en) begin
      s1_vld_q <= point_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_x_q <= point_i.x_pos;
      s1_y_q <= point_i.y_pos;
    end
  end

  // Stage 2: exact squares, and the vector scaled by the guard bits. A point in the left
  // half-plane is turned by half a turn so the CORDIC only sees x >= 0.
  assign xx_s = psc_pkg::SQ_W'(s1_x_q) * psc_pkg::SQ_W'(s1_x_q);
  assign yy_s = psc_pkg::SQ_W'(s1_y_q) * psc_pkg::SQ_W'(s1_y_q);
  assign xg   = CW'(s1_x_q) <<< psc_pkg::GUARD_BITS;
  assign yg   = CW'(s1_y_q) <<< psc_pkg::GUARD_BITS;

  always_comb begin
    if (s1_x_q[psc_pkg::COORD_W-1]) begin
      s2_vec_d.x = -xg;
      s2_vec_d.y = -yg;
      s2_vec_d.z = A'(1) << (A - 1);
    end else begin
      s2_vec_d.x = xg;
      s2_vec_d.y = yg;
      s2_vec_d.z = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else if (en) begin
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_xx_q     <= xx_s;
      s2_yy_q     <= yy_s;
      s2_vec_q    <= s2_vec_d;
      s2_origin_q <= (s1_x_q == '0) && (s1_y_q == '0);
    end
  end

  // Region test runs beside the first micro-rotation; the outer test takes priority.
  assign r2 = s2_xx_q + s2_yy_q;

  always_comb begin
    side_d.origin = s2_origin_q;
    if (r2 > out2_q) begin
      side_d.region = psc_pkg::REGION_OUTER;
    end else if (r2 < in2_q) begin
      side_d.region = psc_pkg::REGION_INNER;
    end else begin
      side_d.region = psc_pkg::REGION_RING;
    end
  end

  psc_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s2_vld_q),
    .vec_i   (s2_vec_q),
    .side_i  (side_d),
    .valid_o (c_vld),
    .angle_o (c_angle),
    .side_o  (c_side)
  );

  // Sector index: the angle scaled by the count, keeping the integer part.
  assign angle_eff = c_side.origin ? '0 : c_angle;
  assign prod      = (A + psc_pkg::COUNT_W)'(angle_eff) * (A + psc_pkg::COUNT_W)'(count_q);

  always_comb begin
    sector_d = '0;
    if (c_side.region == psc_pkg::REGION_RING) begin
      sector_d = prod[A +: psc_pkg::SECTOR_W];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= c_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sector_q <= sector_d;
      region_q <= c_side.region;
    end
  end

  assign result_o.valid  = out_vld_q;
  assign result_o.sector = sector_q;
  assign result_o.region = region_q;

  a_off_ring_sector_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && region_q != psc_pkg::REGION_RING |-> sector_q == '0)
    else $error("non-zero sector reported off the ring");

  a_sector_below_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && region_q == psc_pkg::REGION_RING
      |-> psc_pkg::COUNT_W'(sector_q) < count_q)
    else $error("sector index not below the sector count");

endmodule

// ===== rtl/psc_cordic.sv =====
// Pipelined vectoring CORDIC, one micro-rotation per register stage.
module psc_cordic (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  valid_i,
  input  psc_pkg::psc_vec_t     vec_i,
  input  psc_pkg::psc_side_t    side_i,
  output logic                  valid_o,
  output logic [psc_pkg::ANGLE_BITS-1:0] angle_o,
  output psc_pkg::psc_side_t    side_o
);

  localparam int N = psc_pkg::CORDIC_STAGES;
  localparam int W = psc_pkg::CORDIC_W;

  logic [N-1:0]       vld_q;
  psc_pkg::psc_vec_t  vec_q  [N];
  psc_pkg::psc_side_t side_q [N];

  for (genvar i = 0; i < N; i++) begin : g_stage
    localparam logic [psc_pkg::ANGLE_BITS-1:0] Step = psc_pkg::atan_entry(5'(i));

    logic               vld_prev;
    psc_pkg::psc_vec_t  vec_prev;
    psc_pkg::psc_side_t side_prev;
    psc_pkg::psc_vec_t  vec_d;
    logic signed [W-1:0] xp, yp, dx, dy;

    if (i == 0) begin : g_first
      assign vld_prev  = valid_i;
      assign vec_prev  = vec_i;
      assign side_prev = side_i;
    end else begin : g_next
      assign vld_prev  = vld_q[i-1];
      assign vec_prev  = vec_q[i-1];
      assign side_prev = side_q[i-1];
    end

    assign xp = vec_prev.x;
    assign yp = vec_prev.y;
    assign dx = yp >>> i;
    assign dy = xp >>> i;

    // Rotate towards the x axis; the sign of y picks the direction.
    always_comb begin
      vec_d = vec_prev;
      if (!yp[W-1]) begin
        vec_d.x = xp + dx;
        vec_d.y = yp - dy;
        vec_d.z = vec_prev.z + Step;
      end else begin
        vec_d.x = xp - dx;
        vec_d.y = yp + dy;
        vec_d.z = vec_prev.z - Step;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else if (en_i) begin
        vld_q[i] <= vld_prev;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        vec_q[i]  <= vec_d;
        side_q[i] <= side_prev;
      end
    end
  end

  assign valid_o = vld_q[N-1];
  assign angle_o = vec_q[N-1].z;
  assign side_o  = side_q[N-1];

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en_i |=> $stable(vld_q) && $stable(angle_o))
    else $error("CORDIC pipeline moved while stalled");

  a_bubble_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i && !valid_i |=> !vld_q[0])
    else $error("empty slot did not enter the first stage");

  a_valid_shifts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i |=> vld_q[N-1] == $past(vld_q[N-2]))
    else $error("valid bit did not advance with its data");

endmodule
